[hdl/ppm1_pkg.sv]
// shared types and constants for the p-1 factor search
package ppm1_pkg;
  localparam int unsigned NumBits   = 32;
  localparam int unsigned LimitBits = 20;
  localparam logic [LimitBits-1:0] LimitReset = 20'd10000;

  localparam logic [1:0] OutFound     = 2'd0;
  localparam logic [1:0] OutGcdEqual  = 2'd1;
  localparam logic [1:0] OutExhausted = 2'd2;

  localparam logic [1:0] RegLimit = 2'd0;
endpackage

[hdl/ppm1_modunit.sv]
// shared bit-serial modulo unit: remainder of a 64-bit dividend by a 32-bit divisor
module ppm1_modunit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        go_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] rem_o
);
  logic [63:0] dvd_q, dvd_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] div_q, div_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [32:0] shifted;
  logic [32:0] diff;

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_o = 1'b0;
    shifted = {rem_q[31:0], dvd_q[63]};
    diff    = shifted - {1'b0, div_q};
    if (go_i) begin
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[62:0], 1'b0};
      rem_d = diff[32] ? shifted : diff;
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  assign rem_o = rem_d[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end
endmodule

[hdl/ppm1_seq.sv]
// sequencer for exponentiation, euclid and search control
module ppm1_seq (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] number_i,
  input  logic [ppm1_pkg::LimitBits-1:0] limit_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [31:0] factor_o,
  output logic [1:0]  outcome_o,
  output logic        mgo_o,
  output logic [63:0] mdvd_o,
  output logic [31:0] mdiv_o,
  input  logic        mdone_i,
  input  logic [31:0] mrem_i
);
  localparam logic [3:0] StIdle = 4'd0, StBaseMod = 4'd1, StExpChk = 4'd2,
    StMul = 4'd3, StSqr = 4'd4, StEucChk = 4'd5, StEucMod = 4'd6, StDone = 4'd7;

  logic [3:0]  st_q, st_d;
  logic [31:0] n_q, n_d, pow_q, pow_d, acc_q, acc_d, sq_q, sq_d, ex_q, ex_d, ey_q, ey_d;
  logic [ppm1_pkg::LimitBits-1:0] idx_q, idx_d, bits_q, bits_d;
  logic [31:0] fac_q, fac_d;
  logic [1:0]  oc_q, oc_d;
  logic        wait_q, wait_d;
  logic [31:0] g;

  always_comb begin
    st_d = st_q; n_d = n_q; pow_d = pow_q; acc_d = acc_q; sq_d = sq_q;
    ex_d = ex_q; ey_d = ey_q; idx_d = idx_q; bits_d = bits_q;
    fac_d = fac_q; oc_d = oc_q; wait_d = wait_q;
    mgo_o = 1'b0; mdvd_o = '0; mdiv_o = n_q; done_o = 1'b0;
    g = ex_q;
    unique case (st_q)
      StIdle: begin
        if (start_i) begin
          n_d = number_i; fac_d = '0; oc_d = ppm1_pkg::OutExhausted;
          if (number_i < 32'd2) begin
            oc_d = ppm1_pkg::OutGcdEqual; st_d = StDone;
          end else if (limit_i < 20'd2) begin
            st_d = StDone;
          end else begin
            pow_d = 32'd2; idx_d = 20'd2; st_d = StBaseMod; wait_d = 1'b0;
          end
        end
      end
      StBaseMod: begin
        if (!wait_q) begin
          mgo_o = 1'b1; mdvd_o = {32'd0, pow_q}; wait_d = 1'b1;
        end else if (mdone_i) begin
          wait_d = 1'b0; sq_d = mrem_i; acc_d = 32'd1; bits_d = idx_q; st_d = StExpChk;
        end
      end
      StExpChk: begin
        if (bits_q == '0) begin
          pow_d = acc_q;
          ex_d = (acc_q == 32'd0) ? n_q - 32'd1 : acc_q - 32'd1;
          ey_d = n_q; st_d = StEucChk;
        end else if (bits_q[0]) st_d = StMul;
        else st_d = StSqr;
      end
      StMul: begin
        if (!wait_q) begin
          mgo_o = 1'b1; mdvd_o = acc_q * sq_q; wait_d = 1'b1;
        end else if (mdone_i) begin
          wait_d = 1'b0; acc_d = mrem_i; st_d = StSqr;
        end
      end
      StSqr: begin
        if (!wait_q) begin
          mgo_o = 1'b1; mdvd_o = sq_q * sq_q; wait_d = 1'b1;
        end else if (mdone_i) begin
          wait_d = 1'b0; sq_d = mrem_i; bits_d = bits_q >> 1; st_d = StExpChk;
        end
      end
      StEucChk: begin
        if (ey_q == '0) begin
          if (g > 32'd1 && g < n_q) begin
            fac_d = g; oc_d = ppm1_pkg::OutFound; st_d = StDone;
          end else if (g == n_q) begin
            oc_d = ppm1_pkg::OutGcdEqual; st_d = StDone;
          end else if (idx_q >= limit_i) begin
            st_d = StDone;
          end else begin
            idx_d = idx_q + 20'd1; st_d = StBaseMod;
          end
        end else st_d = StEucMod;
      end
      StEucMod: begin
        mdiv_o = ey_q;
        if (!wait_q) begin
          mgo_o = 1'b1; mdvd_o = {32'd0, ex_q}; wait_d = 1'b1;
        end else if (mdone_i) begin
          wait_d = 1'b0; ex_d = ey_q; ey_d = mrem_i; st_d = StEucChk;
        end
      end
      StDone: begin
        done_o = 1'b1; st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  assign busy_o    = (st_q != StIdle);
  assign factor_o  = fac_q;
  assign outcome_o = oc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; wait_q <= 1'b0;
      fac_q <= '0; oc_q <= '0;
    end else begin
      st_q <= st_d; wait_q <= wait_d;
      fac_q <= fac_d; oc_q <= oc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; pow_q <= pow_d; acc_q <= acc_d; sq_q <= sq_d;
    ex_q <= ex_d; ey_q <= ey_d; idx_q <= idx_d; bits_q <= bits_d;
  end
endmodule

[hdl/pollard_p_minus_1_factor.sv]
// top level of the pollard p-1 factor search
// each modulo runs on the shared remainder unit; step index i takes one base modulo, up to
// 2*(floor(log2 i)+1) exponent modulos and one per euclid step, plus an exponent check
// per exponent bit and a euclid check per euclid step
// number below 2 or limit below 2: result strobe in the cycle after the accepting edge
// one transaction at a time, busy high until the strobe, results cannot be stalled;
// asynchronous active-low reset idles the sequencer and sets the limit to 10000
module pollard_p_minus_1_factor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] number_in_i,
  output logic        done_o,
  output logic [31:0] factor_out_o,
  output logic [1:0]  outcome_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [ppm1_pkg::LimitBits-1:0] limit_q;
  logic        mgo, mdone;
  logic [63:0] mdvd;
  logic [31:0] mdiv, mrem;
  logic        limit_sel;

  assign limit_sel = (paddr == 2'(ppm1_pkg::RegLimit << 2));
  assign pready = 1'b1;
  assign prdata = limit_sel ? {12'd0, limit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) limit_q <= ppm1_pkg::LimitReset;
    else if (psel && penable && pwrite && limit_sel) limit_q <= pwdata[19:0];
  end

  ppm1_seq u_seq (
    .clk_i, .rst_ni,
    .start_i(start & ~busy), .number_i(number_in_i), .limit_i(limit_q),
    .busy_o(busy), .done_o, .factor_o(factor_out_o), .outcome_o,
    .mgo_o(mgo), .mdvd_o(mdvd), .mdiv_o(mdiv), .mdone_i(mdone), .mrem_i(mrem)
  );

  ppm1_modunit u_mod (
    .clk_i, .rst_ni, .go_i(mgo), .dividend_i(mdvd), .divisor_i(mdiv),
    .done_o(mdone), .rem_o(mrem)
  );
endmodule

[hdl/ppm1_checker.sv]
// port-level checks for the factor search, bound to the top level
module ppm1_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [31:0] factor_out_o,
  input logic [1:0]  outcome_o
);
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("result without transaction");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted without busy");
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && outcome_o != ppm1_pkg::OutFound) |-> factor_out_o == 32'd0)
    else $error("bad factor");
  a_found_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && outcome_o == ppm1_pkg::OutFound) |-> factor_out_o > 32'd1)
    else $error("trivial factor");
endmodule

bind pollard_p_minus_1_factor ppm1_checker u_chk (.*);

[verif/pollard_p_minus_1_factor_tb.sv]
// self-checking testbench for the pollard p-1 factor search
module pollard_p_minus_1_factor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned CycleLimit = 50_000_000;
  localparam int unsigned SettleCycles = 200;

  typedef struct packed {
    logic [31:0] factor;
    logic [1:0]  outcome;
  } factor_result_t;

  typedef struct {
    logic [31:0]                    number;
    logic [ppm1_pkg::LimitBits-1:0] limit;
    bit                             typed;
    logic [31:0]                    factor;
    logic [1:0]                     outcome;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [31:0] number_in_i;
  logic        done_o;
  logic [31:0] factor_out_o;
  logic [1:0]  outcome_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  factor_result_t                 expected_results[$];
  logic [ppm1_pkg::LimitBits-1:0] model_limit;
  int unsigned                    error_count;
  int unsigned                    items_sent;
  int unsigned                    results_seen;
  longint unsigned                cycle_count = 0;

  pollard_p_minus_1_factor DUT (.*);

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout with %0d results outstanding", expected_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    error_count++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  function automatic factor_result_t predict_factor(input logic [31:0] n,
                                                    input logic [ppm1_pkg::LimitBits-1:0] lim);
    factor_result_t   r;
    logic [31:0]      base;
    logic [31:0]      acc;
    logic [31:0]      sq;
    logic [31:0]      t;
    logic [31:0]      x;
    logic [31:0]      y;
    logic [31:0]      rem;
    logic [ppm1_pkg::LimitBits-1:0] bits;
    longint unsigned  i;
    r.factor = '0;
    r.outcome = ppm1_pkg::OutExhausted;
    if (n < 2) begin
      r.outcome = ppm1_pkg::OutGcdEqual;
      return r;
    end
    base = 32'd2;
    for (i = 2; i <= lim; i++) begin
      acc = 32'd1;
      sq = base % n;
      bits = ppm1_pkg::LimitBits'(i);
      while (bits != 0) begin
        if (bits[0])
          acc = 32'((64'(acc) * 64'(sq)) % 64'(n));
        sq = 32'((64'(sq) * 64'(sq)) % 64'(n));
        bits = bits >> 1;
      end
      base = acc;
      t = (base == 0) ? n - 1 : base - 1;
      x = t;
      y = n;
      while (y != 0) begin
        rem = x % y;
        x = y;
        y = rem;
      end
      if (x > 1 && x < n) begin
        r.factor = x;
        r.outcome = ppm1_pkg::OutFound;
        return r;
      end
      if (x == n) begin
        r.outcome = ppm1_pkg::OutGcdEqual;
        return r;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    factor_result_t want;
    if (rst_ni && done_o) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result factor %0d outcome %0d",
                                  factor_out_o, outcome_o));
      end else begin
        want = expected_results.pop_front();
        if (factor_out_o !== want.factor)
          report_mismatch($sformatf("factor_out %0d, expected %0d",
                                    factor_out_o, want.factor));
        if (outcome_o !== want.outcome)
          report_mismatch($sformatf("outcome %0d, expected %0d", outcome_o, want.outcome));
      end
    end
  end

  task automatic wait_idle();
    while (expected_results.size() != 0 || busy)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [ppm1_pkg::LimitBits-1:0] value);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 2'(ppm1_pkg::RegLimit << 2);
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    model_limit = value;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[ppm1_pkg::LimitBits-1:0] !== value)
      report_mismatch($sformatf("limit reads %0d, expected %0d", prdata, value));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // leaves start high; the caller lowers it when a gap follows
  task automatic send_number(input logic [31:0] n, input bit typed,
                             input factor_result_t typed_result);
    start       <= 1'b1;
    number_in_i <= n;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    expected_results.push_back(typed ? typed_result : predict_factor(n, model_limit));
    items_sent++;
  endtask

  task automatic sender_gap(input int unsigned idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(20, 1)) @(posedge clk_i);
    end
  endtask

  function automatic logic [31:0] random_number();
    case ($urandom_range(4))
      0: return $urandom();
      1: return 32'($urandom_range(65535, 2));
      2: return 32'($urandom_range(3)) << $urandom_range(31);
      default: return 32'($urandom_range(1000, 0));
    endcase
  endfunction

  stim_row_t directed_rows[18] = '{
    '{32'd0,          ppm1_pkg::LimitReset, 1'b1, 32'd0, ppm1_pkg::OutGcdEqual},
    '{32'd1,          ppm1_pkg::LimitReset, 1'b1, 32'd0, ppm1_pkg::OutGcdEqual},
    '{32'd3,          ppm1_pkg::LimitReset, 1'b1, 32'd0, ppm1_pkg::OutGcdEqual},
    '{32'd15,         ppm1_pkg::LimitReset, 1'b1, 32'd3, ppm1_pkg::OutFound},
    '{32'd15,         20'd0,                1'b1, 32'd0, ppm1_pkg::OutExhausted},
    '{32'hFFFF_FFFF,  20'd0,                1'b1, 32'd0, ppm1_pkg::OutExhausted},
    '{32'd15,         20'd1,                1'b1, 32'd0, ppm1_pkg::OutExhausted},
    '{32'd3,          20'hFFFFF,            1'b1, 32'd0, ppm1_pkg::OutGcdEqual},
    '{32'd35,         20'hFFFFF,            1'b0, 32'd0, ppm1_pkg::OutFound},
    '{32'd0,          20'hFFFFF,            1'b1, 32'd0, ppm1_pkg::OutGcdEqual},
    '{32'd4,          20'd6,                1'b0, 32'd0, ppm1_pkg::OutFound},
    '{32'd2,          20'd6,                1'b0, 32'd0, ppm1_pkg::OutFound},
    '{32'hFFFF_FFFF,  20'd6,                1'b1, 32'd3, ppm1_pkg::OutFound},
    '{32'h8000_0000,  20'd6,                1'b0, 32'd0, ppm1_pkg::OutFound},
    '{32'hFFFF_FFFB,  20'd6,                1'b0, 32'd0, ppm1_pkg::OutFound},
    '{32'd1_000_003,  20'd6,                1'b0, 32'd0, ppm1_pkg::OutFound},
    '{32'h5555_5555,  20'd6,                1'b0, 32'd0, ppm1_pkg::OutFound},
    '{32'hAAAA_AAAA,  20'd6,                1'b0, 32'd0, ppm1_pkg::OutFound}
  };

  initial begin
    int unsigned idle_pct[3] = '{13, 58, 0};
    factor_result_t typed_result;
    logic [ppm1_pkg::LimitBits-1:0] phase_limit;
    rst_ni = 1'b0;
    start = 1'b0;
    number_in_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    error_count = 0;
    items_sent = 0;
    results_seen = 0;
    model_limit = ppm1_pkg::LimitReset;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[k]) begin
      if (directed_rows[k].limit != model_limit) begin
        start <= 1'b0;
        write_limit(directed_rows[k].limit);
      end
      typed_result.factor = directed_rows[k].factor;
      typed_result.outcome = directed_rows[k].outcome;
      send_number(directed_rows[k].number, directed_rows[k].typed, typed_result);
      sender_gap(30);
    end
    start <= 1'b0;

    foreach (idle_pct[p]) begin
      phase_limit = 20'($urandom_range(6, 2));
      write_limit(phase_limit);
      for (int j = 0; j < 28; j++) begin
        send_number(random_number(), 1'b0, typed_result);
        if (j == 14) begin
          start <= 1'b0;
          while (expected_results.size() != 0) @(posedge clk_i);
        end else begin
          sender_gap(idle_pct[p]);
        end
      end
      start <= 1'b0;
    end

    wait_idle();
    $display("%0d numbers factored, %0d results checked, limits from 0 to 1048575",
             items_sent, results_seen);
    $display("sender idling at 13, 58 and 0 percent, %0d mismatches", error_count);
    if (error_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end
endmodule
